// ===== sv/rtgb_pkg.sv =====
// Shared types and constants for the RAW12 to grayscale BMP byte streamer.
// Holds the result item struct, config and op codes, and the header byte function.
// No dependencies.
package rtgb_pkg;

    // Header length: 14-byte file header, 40-byte info header, 1024-byte palette
    localparam logic [10:0] HEADER_BYTES   = 11'd1078;
    localparam logic [10:0] PALETTE_START  = 11'd54;
    localparam logic [31:0] DATA_OFFSET    = 32'd1078;
    localparam logic [31:0] INFO_SIZE      = 32'h28;
    localparam logic [31:0] PLANES_BPP     = 32'h0008_0001;
    localparam logic [31:0] COLORS_USED    = 32'hFF;
    localparam logic [7:0]  MAGIC_B        = 8'h42;
    localparam logic [7:0]  MAGIC_M        = 8'h4d;

    // Index of each 4-byte header field, counted from byte 2
    localparam logic [8:0] FLD_FILE_SIZE   = 9'd0;
    localparam logic [8:0] FLD_DATA_OFFSET = 9'd2;
    localparam logic [8:0] FLD_INFO_SIZE   = 9'd3;
    localparam logic [8:0] FLD_WIDTH       = 9'd4;
    localparam logic [8:0] FLD_HEIGHT      = 9'd5;
    localparam logic [8:0] FLD_PLANES_BPP  = 9'd6;
    localparam logic [8:0] FLD_IMAGE_SIZE  = 9'd8;
    localparam logic [8:0] FLD_COLORS      = 9'd11;

    // Input op codes
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    // Config register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_run;
        logic       end_of_file;
        logic       refused;
    } result_t;

    typedef struct packed {
        logic [13:0] width;
        logic [13:0] height;
        logic [27:0] total;
    } cfg_t;

    // Byte k of a little-endian 32-bit word
    function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[7:0];
            2'd1:    b = v[15:8];
            2'd2:    b = v[23:16];
            default: b = v[31:24];
        endcase
        return b;
    endfunction

    // Header byte at position pos (pos below HEADER_BYTES)
    function automatic logic [7:0] header_byte(input logic [10:0] pos, input cfg_t cfg);
        logic [10:0] off;
        logic [10:0] rel;
        logic [8:0]  fld;
        logic [31:0] v;
        logic [7:0]  b;
        off = pos - PALETTE_START;
        rel = pos - 11'd2;
        fld = rel[10:2];
        case (fld)
            FLD_FILE_SIZE:   v = DATA_OFFSET + {4'b0, cfg.total};
            FLD_DATA_OFFSET: v = DATA_OFFSET;
            FLD_INFO_SIZE:   v = INFO_SIZE;
            FLD_WIDTH:       v = {18'b0, cfg.width};
            FLD_HEIGHT:      v = {18'b0, cfg.height};
            FLD_PLANES_BPP:  v = PLANES_BPP;
            FLD_IMAGE_SIZE:  v = {4'b0, cfg.total};
            FLD_COLORS:      v = COLORS_USED;
            default:         v = 32'b0;
        endcase
        if (pos >= PALETTE_START)
        begin
            // palette entry: B, G, R = index, then a zero byte
            b = (off[1:0] == 2'd3) ? 8'h00 : off[9:2];
        end
        else if (pos == 11'd0)
        begin
            b = MAGIC_B;
        end
        else if (pos == 11'd1)
        begin
            b = MAGIC_M;
        end
        else
        begin
            b = le_byte(v, rel[1:0]);
        end
        return b;
    endfunction

endpackage

// ===== sv/raw12_to_gray_bmp_stream_top.sv =====
// RAW12 to 8-bit grayscale BMP byte streamer, top level.
// Depends on rtgb_pkg, rtgb_cfg, rtgb_engine, rtgb_out_reg.
//
// Use:
//   Write image_width (index 0) and image_height (index 1) on the config
//   channel while the stream is idle; cfg_ready is always high.
//   Send 1078 header requests (op 0), each returning the next header byte,
//   then pixel items (op 1), each a packed RAW12 group returning two bytes
//   (one byte when a single pixel remains). Items in the wrong phase return
//   one byte of zero with refused set.
// Timing:
//   Results pass from the input register into the single byte-wide output
//   register. Header requests sustain one item per cycle while out_stall
//   is low; a pixel group holds the input register until both its bytes load.
// Reset:
//   rst_n clears the stream position and restores width and height to 1.
// Stall:
//   While out_stall is high the output item holds, and in_stall rises as
//   soon as the input register holds an item that cannot move on.
module raw12_to_gray_bmp_stream_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [23:0] raw_group,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        end_of_run,
    output logic        end_of_file,
    output logic        refused,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);
    import rtgb_pkg::*;

    cfg_t    cfg;
    logic    can_load;
    logic    load;
    result_t load_data;
    result_t out_data;

    rtgb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtgb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .raw_group (raw_group),
        .can_load  (can_load),
        .load      (load),
        .load_data (load_data)
    );

    rtgb_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (load_data),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign data_byte   = out_data.data_byte;
    assign end_of_run  = out_data.end_of_run;
    assign end_of_file = out_data.end_of_file;
    assign refused     = out_data.refused;

endmodule

// ===== sv/rtgb_cfg.sv =====
// Configuration registers: image width, height and their product.
// Depends on rtgb_pkg.
module rtgb_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [13:0]    cfg_data,
    output rtgb_pkg::cfg_t cfg
);
    import rtgb_pkg::*;

    logic [13:0] width_reg;
    logic [13:0] height_reg;
    logic [27:0] total_reg;
    logic [27:0] total_next;
    logic        wr;

    // Writes must come only while idle (unenforced); always ready
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    // Pixel count follows the register being written
    always_comb
    begin
        if (cfg_index == CFG_IDX_WIDTH)
            total_next = {14'b0, cfg_data} * {14'b0, height_reg};
        else
            total_next = {14'b0, width_reg} * {14'b0, cfg_data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 14'd1;
            height_reg <= 14'd1;
            total_reg  <= 28'd1;
        end
        else if (wr)
        begin
            if (cfg_index == CFG_IDX_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
            total_reg <= total_next;
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.total  = total_reg;

endmodule

// ===== sv/rtgb_out_reg.sv =====
// Output result register with valid/stall handshake toward the receiver.
// Depends on rtgb_pkg.
module rtgb_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rtgb_pkg::result_t load_data,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_stall,
    output rtgb_pkg::result_t out_data
);
    import rtgb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or when the held item leaves this cycle
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // A held item is not replaced while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |-> !load)
        else $error("output register overwritten while stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (valid_reg && data_reg == $past(load_data)))
        else $error("loaded item not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled item lost");

endmodule

// ===== sv/rtgb_engine.sv =====
// Input register, stream position state and result decode for one item.
// Depends on rtgb_pkg; feeds rtgb_out_reg.
module rtgb_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  rtgb_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [23:0]       raw_group,
    input  logic              can_load,
    output logic              load,
    output rtgb_pkg::result_t load_data
);
    import rtgb_pkg::*;

    logic        held_reg;
    logic        held_next;
    logic        op_reg;
    logic [7:0]  pix_a_reg;
    logic [7:0]  pix_b_reg;
    logic        phase_reg;
    logic [10:0] hdr_pos_reg;
    logic [26:0] pix_cnt_reg;

    logic        accept;
    logic        release_item;
    logic        hdr_done;
    logic        refuse;
    logic [27:0] left;
    logic        one_left;
    logic        single;
    logic        last;
    result_t     res0;
    result_t     res1;

    // Decode of the held item against the current stream position
    assign hdr_done = hdr_pos_reg >= HEADER_BYTES;
    assign left     = cfg.total - {1'b0, pix_cnt_reg};
    assign one_left = left == 28'd1;
    always_comb
    begin
        if (op_reg == OP_HEADER)
            refuse = hdr_done;
        else
            refuse = !hdr_done || ({1'b0, pix_cnt_reg} >= cfg.total);
    end
    assign single = refuse || (op_reg == OP_HEADER) || one_left;

    // First and second result of the item
    always_comb
    begin
        res0 = '0;
        if (refuse)
        begin
            res0.end_of_run = 1'b1;
            res0.refused    = 1'b1;
        end
        else if (op_reg == OP_HEADER)
        begin
            res0.data_byte  = header_byte(hdr_pos_reg, cfg);
            res0.end_of_run = 1'b1;
        end
        else
        begin
            res0.data_byte   = pix_a_reg;
            res0.end_of_run  = one_left;
            res0.end_of_file = one_left;
        end
        res1.data_byte   = pix_b_reg;
        res1.end_of_run  = 1'b1;
        res1.end_of_file = left == 28'd2;
        res1.refused     = 1'b0;
    end

    assign last         = phase_reg || single;
    assign load         = held_reg && can_load;
    assign release_item = load && last;
    assign load_data    = phase_reg ? res1 : res0;

    // Input register takes a new item once the held one is finished
    assign in_stall = held_reg && !release_item;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            held_next = 1'b1;
        else if (release_item)
            held_next = 1'b0;
        else
            held_next = held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            hdr_pos_reg <= 11'd0;
            pix_cnt_reg <= 27'd0;
        end
        else
        begin
            held_reg <= held_next;
            if (release_item)
                phase_reg <= 1'b0;
            else if (load)
                phase_reg <= 1'b1;
            // Position advances when a non-refused item is done
            if (release_item && !refuse)
            begin
                if (op_reg == OP_HEADER)
                    hdr_pos_reg <= hdr_pos_reg + 11'd1;
                else if (one_left)
                    pix_cnt_reg <= pix_cnt_reg + 27'd1;
                else
                    pix_cnt_reg <= pix_cnt_reg + 27'd2;
            end
        end
    end

    // Payload capture: samples keep only their low 8 bits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            pix_a_reg <= {raw_group[3:0], raw_group[19:16]};
            pix_b_reg <= {raw_group[11:8], raw_group[23:20]};
        end
    end

    a_phase_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (held_reg && op_reg == OP_PIXEL && !refuse && !one_left))
        else $error("second result for an item that has only one");

    a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= HEADER_BYTES)
        else $error("header position past end");

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !release_item |=> ($stable(pix_cnt_reg) && $stable(hdr_pos_reg)))
        else $error("stream position moved without a finished item");

    a_pixel_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (load && op_reg == OP_PIXEL && !load_data.refused) |-> hdr_done)
        else $error("pixel byte before header complete");

endmodule
